// ===== rtl/core/entity_decode_utf8_filter_macros.svh =====
// assertion macros for the entity decode filter
// used by the datapath; needs clk and rst in scope
`ifndef ENTITY_DECODE_UTF8_FILTER_MACROS_SVH
`define ENTITY_DECODE_UTF8_FILTER_MACROS_SVH

// condition implies consequence in the same cycle
`define EDU_ASSERT_IMPL(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// condition implies consequence in the next cycle
`define EDU_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/edu_pkg.sv =====
// shared types, constants and entity tables of the entity decode filter
// no dependencies
`timescale 1ns / 1ps
package edu_pkg;

  localparam int ENTITY_WINDOW_DEF = 10;
  localparam int NUM_ENT = 21;
  localparam logic [4:0] ENT_MISS = 5'd21;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_TAB  = 8'h09;

  typedef enum logic [2:0] {
    S_IDLE, S_FEED, S_RESOLVE, S_EMIT, S_FLUSH, S_NEXT, S_END, S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic feed;
    logic resolve;
    logic emit_ent;
    logic flush;
    logic pop;
    logic end_mark;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic feed_res;
    logic feed_flush;
    logic rep_nz;
    logic fill_nz;
    logic fin;
    logic ent_last;
  } stat_t;

  // entity names, last character in the low byte
  function automatic logic [63:0] ent_name(input logic [4:0] i);
    case (i)
      5'd0:  ent_name = 64'("&amp;");
      5'd1:  ent_name = 64'("&lt;");
      5'd2:  ent_name = 64'("&gt;");
      5'd3:  ent_name = 64'("&quot;");
      5'd4:  ent_name = 64'("&apos;");
      5'd5:  ent_name = 64'("&#39;");
      5'd6:  ent_name = 64'("&#8217;");
      5'd7:  ent_name = 64'("&#8216;");
      5'd8:  ent_name = 64'("&#8220;");
      5'd9:  ent_name = 64'("&#8221;");
      5'd10: ent_name = 64'("&nbsp;");
      5'd11: ent_name = 64'("&mdash;");
      5'd12: ent_name = 64'("&ndash;");
      5'd13: ent_name = 64'("&hellip;");
      5'd14: ent_name = 64'("&ldquo;");
      5'd15: ent_name = 64'("&rdquo;");
      5'd16: ent_name = 64'("&lsquo;");
      5'd17: ent_name = 64'("&rsquo;");
      5'd18: ent_name = 64'("&ntilde;");
      5'd19: ent_name = 64'("&eacute;");
      5'd20: ent_name = 64'("&uuml;");
      default: ent_name = '0;
    endcase
  endfunction

  function automatic logic [3:0] ent_name_len(input logic [4:0] i);
    case (i)
      5'd1, 5'd2: ent_name_len = 4'd4;
      5'd0, 5'd5: ent_name_len = 4'd5;
      5'd3, 5'd4, 5'd10, 5'd20: ent_name_len = 4'd6;
      5'd6, 5'd7, 5'd8, 5'd9, 5'd11, 5'd12, 5'd14, 5'd15, 5'd16, 5'd17:
        ent_name_len = 4'd7;
      5'd13, 5'd18, 5'd19: ent_name_len = 4'd8;
      default: ent_name_len = 4'd0;
    endcase
  endfunction

  // replacement text, last character in the low byte
  function automatic logic [23:0] ent_text(input logic [4:0] i);
    case (i)
      5'd0:  ent_text = 24'("&");
      5'd1:  ent_text = 24'("<");
      5'd2:  ent_text = 24'(">");
      5'd3, 5'd8, 5'd9, 5'd14, 5'd15: ent_text = 24'("\"");
      5'd4, 5'd5, 5'd6, 5'd7, 5'd16, 5'd17: ent_text = 24'("'");
      5'd10: ent_text = 24'(" ");
      5'd11: ent_text = 24'(" - ");
      5'd12: ent_text = 24'("-");
      5'd13: ent_text = 24'("...");
      5'd18: ent_text = 24'("n");
      5'd19: ent_text = 24'("e");
      5'd20: ent_text = 24'("u");
      default: ent_text = 24'("-");
    endcase
  endfunction

  function automatic logic [1:0] ent_text_len(input logic [4:0] i);
    case (i)
      5'd11, 5'd13: ent_text_len = 2'd3;
      default: ent_text_len = 2'd1;
    endcase
  endfunction

endpackage

// ===== rtl/core/edu_if.sv =====
// stream interfaces of the entity decode filter: input and output channels
// no dependencies
`timescale 1ns / 1ps
interface edu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;
  modport source (output valid, in_byte, final_byte, input ready);
  modport sink (input valid, in_byte, final_byte, output ready);
endinterface

interface edu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_marker;
  logic       run_last;
  modport source (output valid, out_byte, end_marker, run_last, input ready);
  modport sink (input valid, out_byte, end_marker, run_last, output ready);
endinterface

// ===== rtl/core/edu_ctrl.sv =====
// sequencer of the entity decode filter: one state per step of a byte
// depends on edu_pkg
`timescale 1ns / 1ps
module edu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  edu_pkg::stat_t st,
  output edu_pkg::cmd_t  cmd
);
  import edu_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_FEED;
        end
      end
      S_FEED: begin
        if (st.ok) begin
          cmd.feed = 1'b1;
          if (st.feed_res) state_next = S_RESOLVE;
          else if (st.feed_flush) state_next = S_FLUSH;
          else state_next = S_NEXT;
        end
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.ok) begin
          cmd.emit_ent = 1'b1;
          if (st.ent_last) state_next = S_NEXT;
        end
      end
      S_FLUSH: begin
        if (st.ok) begin
          cmd.flush = 1'b1;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (st.rep_nz) begin
          cmd.pop = 1'b1;
          state_next = S_FEED;
        end else if (st.fin && st.fill_nz) state_next = S_FLUSH;
        else if (st.fin) state_next = S_END;
        else state_next = S_FINISH;
      end
      S_END: begin
        if (st.ok) begin
          cmd.end_mark = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (st.ok) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/edu_dp.sv =====
// datapath of the entity decode filter: window, replay queue, utf-8 state,
// one-item hold stage and output register; depends on edu_pkg and the macros
`timescale 1ns / 1ps
`include "entity_decode_utf8_filter_macros.svh"
module edu_dp #(
  parameter int ENTITY_WINDOW = edu_pkg::ENTITY_WINDOW_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_byte,
  input  logic          final_byte,
  input  edu_pkg::cmd_t  cmd,
  output edu_pkg::stat_t st,
  edu_out_if.source     dst
);
  import edu_pkg::*;

  localparam int FILLW = $clog2(ENTITY_WINDOW + 1);
  localparam int IDXW = $clog2(ENTITY_WINDOW);
  localparam int REPW = $clog2(ENTITY_WINDOW);

  logic [7:0]       win [ENTITY_WINDOW];
  logic [7:0]       rep [ENTITY_WINDOW-1];
  logic [FILLW-1:0] fill;
  logic [REPW-1:0]  rep_cnt;
  logic [1:0]       mb_left;
  logic             mb_keep;
  logic [7:0]       cur;
  logic             fin;
  logic [4:0]       ent_sel;
  logic [1:0]       ent_k;
  logic             hold_v;
  logic [7:0]       hold_byte;
  logic             hold_end;
  logic             out_v;
  logic [7:0]       out_b;
  logic             out_end;
  logic             out_last;

  logic             ok;
  logic [FILLW-1:0] fill_inc;
  logic [4:0]       match;
  logic [1:0]       tlen;
  logic [23:0]      ttext;
  logic [7:0]       tchar;

  assign ok = !out_v || dst.ready;
  assign fill_inc = fill + 1'b1;
  assign tlen = ent_text_len(ent_sel);
  assign ttext = ent_text(ent_sel);

  always_comb begin
    int base;
    base = 8 * (int'(tlen) - 1 - int'(ent_k));
    tchar = ttext[base +: 8];
  end

  // compare the window against every entity name
  always_comb begin
    logic [63:0] nm;
    logic [3:0]  ln;
    logic        same;
    match = ENT_MISS;
    for (int i = NUM_ENT - 1; i >= 0; i--) begin
      nm = ent_name(5'(i));
      ln = ent_name_len(5'(i));
      same = (fill == FILLW'(ln));
      for (int k = 0; k < 8; k++) begin
        if (k < int'(ln) && win[k] != nm[8 * (int'(ln) - 1 - k) +: 8]) same = 1'b0;
      end
      if (same) match = 5'(i);
    end
  end

  always_comb begin
    st.ok = ok;
    st.feed_res = (fill != '0) && (cur == CH_SEMI);
    st.feed_flush = (fill != '0) && (cur != CH_SEMI) &&
                    (fill_inc >= FILLW'(ENTITY_WINDOW));
    st.rep_nz = (rep_cnt != '0);
    st.fill_nz = (fill != '0);
    st.fin = fin;
    st.ent_last = (ent_k == tlen - 2'd1);
  end

  // an emitted item waits in the hold stage until the next one shows whether it is last
  logic       em;
  logic [7:0] em_byte;
  logic       em_end;

  always_comb begin
    em = 1'b0;
    em_byte = cur;
    em_end = 1'b0;
    if (cmd.feed) begin
      if (fill != '0) em = 1'b0;
      else if (mb_left != 2'd0) em = mb_keep;
      else if (cur == CH_AMP) em = 1'b0;
      else if (cur[7]) em = ((cur & 8'hE0) == 8'hC0) && (cur == 8'hD6 || cur == 8'hD7);
      else begin
        em = 1'b1;
        if (cur == CH_LF || cur == CH_CR || cur == CH_TAB) em_byte = CH_SP;
      end
    end else if (cmd.emit_ent) begin
      em = 1'b1;
      em_byte = tchar;
    end else if (cmd.flush) begin
      em = 1'b1;
      em_byte = CH_AMP;
    end else if (cmd.end_mark) begin
      em = 1'b1;
      em_byte = 8'h00;
      em_end = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      rep_cnt <= '0;
      mb_left <= 2'd0;
      mb_keep <= 1'b0;
      hold_v <= 1'b0;
      out_v <= 1'b0;
      fin <= 1'b0;
    end else begin
      if (em && hold_v) begin
        out_v <= 1'b1;
        out_b <= hold_byte;
        out_end <= hold_end;
        out_last <= 1'b0;
      end else if (cmd.finish && hold_v) begin
        out_v <= 1'b1;
        out_b <= hold_byte;
        out_end <= hold_end;
        out_last <= 1'b1;
      end else if (out_v && dst.ready) begin
        out_v <= 1'b0;
      end
      if (em) begin
        hold_v <= 1'b1;
        hold_byte <= em_byte;
        hold_end <= em_end;
      end else if (cmd.finish) begin
        hold_v <= 1'b0;
      end
      if (cmd.load) begin
        cur <= in_byte;
        fin <= final_byte;
      end
      if (cmd.feed) begin
        if (fill != '0) begin
          win[fill[IDXW-1:0]] <= cur;
          fill <= fill_inc;
        end else if (mb_left != 2'd0) begin
          mb_left <= mb_left - 2'd1;
          if (mb_left == 2'd1) mb_keep <= 1'b0;
        end else if (cur == CH_AMP) begin
          win[0] <= cur;
          fill <= FILLW'(1);
        end else if (cur[7]) begin
          if ((cur & 8'hE0) == 8'hC0) begin
            mb_left <= 2'd1;
            mb_keep <= (cur == 8'hD6 || cur == 8'hD7);
          end else if ((cur & 8'hF0) == 8'hE0) begin
            mb_left <= 2'd2;
            mb_keep <= 1'b0;
          end else if ((cur & 8'hF8) == 8'hF0) begin
            mb_left <= 2'd3;
            mb_keep <= 1'b0;
          end
        end
      end
      if (cmd.resolve) begin
        ent_sel <= match;
        ent_k <= 2'd0;
        fill <= '0;
      end
      if (cmd.emit_ent) ent_k <= ent_k + 2'd1;
      if (cmd.flush) begin
        for (int i = 0; i < ENTITY_WINDOW - 1; i++) rep[i] <= win[i + 1];
        rep_cnt <= REPW'(fill - 1'b1);
        fill <= '0;
      end
      if (cmd.pop) begin
        cur <= rep[0];
        for (int i = 0; i < ENTITY_WINDOW - 2; i++) rep[i] <= rep[i + 1];
        rep_cnt <= rep_cnt - 1'b1;
      end
      if (cmd.end_mark) begin
        mb_left <= 2'd0;
        mb_keep <= 1'b0;
      end
    end
  end

  assign dst.valid = out_v;
  assign dst.out_byte = out_b;
  assign dst.end_marker = out_end;
  assign dst.run_last = out_last;

  `EDU_ASSERT_IMPL(a_fill_range, 1'b1, fill <= FILLW'(ENTITY_WINDOW))
  `EDU_ASSERT_IMPL(a_window_or_mb, fill != '0, mb_left == 2'd0)
  `EDU_ASSERT_NEXT(a_finish_drains, cmd.finish, !hold_v)
  `EDU_ASSERT_IMPL(a_marker_zero, hold_v && hold_end, hold_byte == 8'h00)

endmodule

// ===== rtl/core/entity_decode_utf8_filter.sv =====
// top level of the entity decode filter: sequencer plus datapath
// depends on edu_pkg, edu_if, edu_ctrl and edu_dp
//
//   channel | dir | fields                          | handshake
//   src     | in  | in_byte, final_byte             | valid/ready
//   dst     | out | out_byte, end_marker, run_last  | valid/ready
//
// a plain byte goes through accept, process, dispatch and release in turn
// entity replacement adds a lookup step, then emits each replacement byte in turn
// an unmatched window adds a step that emits '&', then each held byte is replayed
// reset is synchronous; no clearing pass; output stalls hold the sequencer
`timescale 1ns / 1ps
module entity_decode_utf8_filter #(
  parameter int ENTITY_WINDOW = edu_pkg::ENTITY_WINDOW_DEF
) (
  input logic        clk,
  input logic        rst,
  edu_in_if.sink     src,
  edu_out_if.source  dst
);
  import edu_pkg::*;

  cmd_t  cmd;
  stat_t st;

  edu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (src.valid),
    .in_ready (src.ready),
    .st       (st),
    .cmd      (cmd)
  );

  edu_dp #(.ENTITY_WINDOW(ENTITY_WINDOW)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (src.in_byte),
    .final_byte (src.final_byte),
    .cmd        (cmd),
    .st         (st),
    .dst        (dst)
  );

endmodule

// ===== sim/tb_entity_decode_utf8_filter.sv =====
// testbench of the entity decode filter: directed table and text, then random texts
// depends on edu_pkg, edu_if and entity_decode_utf8_filter
`timescale 1ns / 1ps
module tb_entity_decode_utf8_filter;
  import edu_pkg::*;

  localparam int WIN = ENTITY_WINDOW_DEF;
  localparam int MAX_OUT = 12;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 200;

  typedef struct {
    logic [7:0] out_byte;
    logic       end_marker;
    logic       run_last;
  } result_t;

  typedef struct {
    logic [7:0] in_byte;
    logic       fin;
    bit         typed;
    logic [7:0] typed_byte;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  edu_in_if  src ();
  edu_out_if dst ();

  entity_decode_utf8_filter u_dut (.clk(clk), .rst(rst), .src(src), .dst(dst));

  always #1 clk = ~clk;

  // filter state as the block should hold it
  logic [7:0]  win_buf [WIN];
  int unsigned win_fill;
  int unsigned mb_left;
  bit          mb_keep;
  logic [7:0]  step_bytes [$];
  result_t     pending_q [$];

  string ent_names [21] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;", "&#39;",
    "&#8217;", "&#8216;", "&#8220;", "&#8221;", "&nbsp;", "&mdash;", "&ndash;",
    "&hellip;", "&ldquo;", "&rdquo;", "&lsquo;", "&rsquo;", "&ntilde;",
    "&eacute;", "&uuml;"};
  string ent_reps [21] = '{"&", "<", ">", "\"", "'", "'", "'", "'", "\"", "\"",
    " ", " - ", "-", "...", "\"", "\"", "'", "'", "n", "e", "u"};

  int src_idle = 0;
  int rcv_stall = 0;
  int fails = 0;
  int quiet_cycles = 0;

  function automatic void put_byte(logic [7:0] b);
    if (step_bytes.size() < MAX_OUT) step_bytes.push_back(b);
  endfunction

  function automatic void resolve_entity();
    bit same;
    for (int i = 0; i < 21; i++) begin
      same = (ent_names[i].len() == win_fill);
      for (int k = 0; same && k < ent_names[i].len(); k++)
        if (ent_names[i][k] != win_buf[k]) same = 0;
      if (same) begin
        for (int k = 0; k < ent_reps[i].len(); k++) put_byte(ent_reps[i][k]);
        win_fill = 0;
        return;
      end
    end
    put_byte("-");
    win_fill = 0;
  endfunction

  function automatic void filter_byte(logic [7:0] b);
    int n;
    if (win_fill > 0) begin
      if (win_fill < WIN) begin
        win_buf[win_fill] = b;
        win_fill++;
      end
      if (b == CH_SEMI) resolve_entity();
      else if (win_fill >= WIN) replay_window();
      return;
    end
    if (mb_left > 0) begin
      mb_left--;
      if (mb_keep) put_byte(b);
      if (mb_left == 0) mb_keep = 0;
      return;
    end
    if (b == CH_AMP) begin
      win_buf[0] = b;
      win_fill = 1;
      return;
    end
    if (b >= 8'h80) begin
      if ((b & 8'hE0) == 8'hC0) n = 2;
      else if ((b & 8'hF0) == 8'hE0) n = 3;
      else if ((b & 8'hF8) == 8'hF0) n = 4;
      else n = 1;
      if (n == 1) return;
      mb_left = n - 1;
      mb_keep = (n == 2) && (b == 8'hD6 || b == 8'hD7);
      if (mb_keep) put_byte(b);
      return;
    end
    if (b == CH_LF || b == CH_CR || b == CH_TAB) put_byte(CH_SP);
    else put_byte(b);
  endfunction

  // unmatched window: '&' then the held bytes go through again
  function automatic void replay_window();
    logic [7:0] held [$];
    for (int i = 1; i < win_fill && i < WIN; i++) held.push_back(win_buf[i]);
    win_fill = 0;
    put_byte(CH_AMP);
    foreach (held[i]) filter_byte(held[i]);
  endfunction

  // runs one accepted item through the filter; results land in step_bytes
  function automatic int filter_item(logic [7:0] b, logic fin);
    step_bytes.delete();
    filter_byte(b);
    if (fin) begin
      while (win_fill > 0) replay_window();
      mb_left = 0;
      mb_keep = 0;
    end
    return step_bytes.size();
  endfunction

  function automatic void push_results(logic fin);
    int total;
    result_t r;
    total = step_bytes.size();
    if (fin && total >= MAX_OUT) total = MAX_OUT - 1;
    for (int k = 0; k < total; k++) begin
      r.out_byte = step_bytes[k];
      r.end_marker = 1'b0;
      r.run_last = (k == total - 1) && !fin;
      pending_q.push_back(r);
    end
    if (fin) begin
      r.out_byte = 8'h00;
      r.end_marker = 1'b1;
      r.run_last = 1'b1;
      pending_q.push_back(r);
    end
  endfunction

  task automatic send_item(logic [7:0] b, logic fin, bit typed, logic [7:0] typed_byte);
    result_t r;
    while ($urandom_range(99) < src_idle) begin
      src.valid <= 1'b0;
      @(posedge clk);
    end
    src.valid <= 1'b1;
    src.in_byte <= b;
    src.final_byte <= fin;
    do @(posedge clk); while (!src.ready);
    void'(filter_item(b, fin));
    if (typed) begin
      r.out_byte = typed_byte;
      r.end_marker = 1'b0;
      r.run_last = 1'b1;
      pending_q.push_back(r);
    end else begin
      push_results(fin);
    end
  endtask

  task automatic send_text(input logic [7:0] text [$]);
    foreach (text[i]) send_item(text[i], i == text.size() - 1, 0, 8'h00);
  endtask

  // one random text of well-formed pieces with some noise
  task automatic make_text(output logic [7:0] text [$]);
    int pieces, kind, n;
    text.delete();
    pieces = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      kind = $urandom_range(0, 11);
      case (kind)
        0, 1, 2, 3: begin
          n = $urandom_range(0, 20);
          for (int k = 0; k < ent_names[n].len(); k++) text.push_back(ent_names[n][k]);
        end
        4: begin
          text.push_back(CH_AMP);
          n = $urandom_range(0, 11);
          for (int k = 0; k < n; k++) text.push_back(8'($urandom_range(8'h61, 8'h7A)));
          if ($urandom_range(1)) text.push_back(CH_SEMI);
        end
        5: begin
          text.push_back($urandom_range(1) ? 8'hD6 : 8'hD7);
          text.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        6: begin
          n = $urandom_range(0, 2);
          text.push_back(8'(n == 0 ? 8'hC0 | $urandom_range(0, 31) :
                            n == 1 ? 8'hE0 | $urandom_range(0, 15) :
                                     8'hF0 | $urandom_range(0, 7)));
          for (int k = 0; k <= n; k++)
            text.push_back(8'($urandom_range(3) == 0 ? $urandom_range(1, 255)
                                                     : $urandom_range(8'h80, 8'hBF)));
        end
        7, 8: text.push_back(8'($urandom_range(1, 255)));
        9: text.push_back($urandom_range(2) == 0 ? CH_LF : ($urandom_range(1) ? CH_CR : CH_TAB));
        default: begin
          n = $urandom_range(1, 5);
          for (int k = 0; k < n; k++) text.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
      endcase
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver, result check and watchdog
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      dst.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      dst.ready <= ($urandom_range(99) >= rcv_stall);
      if ((src.valid && src.ready) || (dst.valid && dst.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (dst.valid && dst.ready) begin
        if (pending_q.size() == 0) begin
          $error("unexpected item out_byte=%h end_marker=%b", dst.out_byte, dst.end_marker);
          fails++;
        end else begin
          e = pending_q.pop_front();
          if (dst.out_byte !== e.out_byte) begin
            $error("out_byte: expected %h, got %h", e.out_byte, dst.out_byte);
            fails++;
          end
          if (dst.end_marker !== e.end_marker) begin
            $error("end_marker: expected %b, got %b", e.end_marker, dst.end_marker);
            fails++;
          end
          if (dst.run_last !== e.run_last) begin
            $error("run_last: expected %b, got %b", e.run_last, dst.run_last);
            fails++;
          end
        end
      end
    end
  end

  row_t directed [] = '{
    '{8'h41, 0, 1, 8'h41}, '{8'h01, 0, 1, 8'h01}, '{8'h7F, 0, 1, 8'h7F},
    '{CH_LF, 0, 1, CH_SP}, '{CH_CR, 0, 1, CH_SP}, '{CH_TAB, 0, 1, CH_SP},
    '{8'hFF, 0, 0, 0}, '{8'h80, 0, 0, 0}, '{8'hD6, 0, 0, 0}, '{8'h91, 0, 0, 0},
    '{8'hE2, 0, 0, 0}, '{CH_AMP, 0, 0, 0}, '{CH_SEMI, 0, 0, 0},
    '{8'hF0, 0, 0, 0}, '{8'h9F, 0, 0, 0}, '{8'h98, 0, 0, 0}, '{8'h80, 0, 0, 0},
    '{CH_AMP, 0, 0, 0}, '{8'h6C, 0, 0, 0}, '{8'h74, 0, 0, 0}, '{CH_SEMI, 0, 0, 0},
    '{CH_AMP, 0, 0, 0}, '{8'h71, 0, 0, 0}, '{CH_SEMI, 0, 0, 0},
    '{CH_AMP, 0, 0, 0}, '{8'h78, 1, 0, 0}
  };

  initial begin
    logic [7:0] text [$];
    int sent;
    src.valid = 1'b0;
    src.in_byte = 8'h00;
    src.final_byte = 1'b0;
    win_fill = 0;
    mb_left = 0;
    mb_keep = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_item(directed[i].in_byte, directed[i].fin, directed[i].typed, directed[i].typed_byte);
    // window that a ';' closes with no matching name, ending in a cut sequence
    text = '{CH_AMP, 8'h61, 8'h62, CH_AMP, 8'h6C, 8'h74, CH_SEMI, 8'h63, 8'h64, 8'h65,
             8'h66, 8'h67, 8'hD7};
    send_text(text);

    for (int phase = 0; phase < 4; phase++) begin
      src_idle = (phase == 1 || phase == 3) ? (phase == 3 ? 38 : 64) : 0;
      rcv_stall = (phase == 2 || phase == 3) ? (phase == 3 ? 38 : 64) : 0;
      // hold off until the block has emptied out
      if (phase == 2) begin
        src.valid <= 1'b0;
        drain();
      end
      sent = 0;
      while (sent < RANDOM_ITEMS / 4) begin
        make_text(text);
        send_text(text);
        sent += text.size();
      end
    end
    src.valid <= 1'b0;
    drain();
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
